### rtl/core/tktr_pkg.sv
// ----------------------------------------------------------------------------
// tktr_pkg
// Shared types and constants of the top-k record tracker: request and result
// formats, list entries, chain operation codes, register indexes.
// ----------------------------------------------------------------------------
package tktr_pkg;

  // sizes
  localparam int MAX_RECORDS_DEF = 16;
  localparam int OUT_LIMIT       = 16;
  localparam int VALUE_W         = 32;
  localparam int ID_W            = 32;
  localparam int RANK_W          = 4;
  localparam int FUNC_W          = 2;
  localparam int CAP_W           = 5;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [ID_W-1:0]           id;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] record_value;
    logic [ID_W-1:0]           record_id;
    logic [RANK_W-1:0]         rank;
    logic                      empty_res;
    logic                      last;
  } rec_t;

  // one list entry held by a cell
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ID_W-1:0]           id;
  } entry_t;

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,      // shift tail-ward from the insert point
    OP_POP_INSERT,  // drop the head, shift head-ward, insert
    OP_ROT_LEFT,    // every cell takes its right neighbor
    OP_ROT_RIGHT    // every cell takes its left neighbor
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    entry_t    offer_entry;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

### rtl/core/tktr_cell.sv
// ----------------------------------------------------------------------------
// tktr_cell
// One slot of the sorted chain. Entries are kept value descending, ties by
// higher id first; the other direction is the same list read from the tail.
// ----------------------------------------------------------------------------
module tktr_cell
  import tktr_pkg::*;
#(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      live,         // slot takes part in the compare
  input  logic      left_ahead,
  input  logic      right_ahead,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      ahead,        // held entry sorts before the offered one
  output entry_t    cur
);

  entry_t cur_next;

  // canonical order compare against the broadcast entry
  assign ahead = live &&
                 (($signed(cur.value) > $signed(ctl.offer_entry.value)) ||
                  ((cur.value == ctl.offer_entry.value) &&
                   (cur.id > ctl.offer_entry.id)));

  // pick the next content from self, neighbors or the offered entry
  always_comb begin
    cur_next = cur;
    unique case (ctl.op)
      OP_INSERT: begin
        if (ahead) begin
          cur_next = cur;
        end else if (IS_HEAD || left_ahead) begin
          cur_next = ctl.offer_entry;
        end else begin
          cur_next = left_entry;
        end
      end
      OP_POP_INSERT: begin
        if (right_ahead) begin
          cur_next = right_entry;
        end else if (IS_HEAD || ahead) begin
          cur_next = ctl.offer_entry;
        end else begin
          cur_next = cur;
        end
      end
      OP_ROT_LEFT:  cur_next = right_entry;
      OP_ROT_RIGHT: cur_next = left_entry;
      default:      cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

endmodule

### rtl/core/top_k_record_tracker_unit.sv
// ----------------------------------------------------------------------------
// top_k_record_tracker_unit
// Sorted top-k list of (value, id) records built as a chain of cells.
// ----------------------------------------------------------------------------
// An offer has every cell compare itself with the offered record at once and
// shifts the chain by at most one slot; a clear only sets the count to zero. A new
// request can follow in the next cycle. A read-out rotates the chain one slot
// per cycle past its output end while the result side does not stall, and it
// holds the request port until it is done; the list is back in place
// when it ends. The list is stored value descending; in the lowest-values
// direction it is read from the tail. There is no clearing pass after reset.
module top_k_record_tracker_unit
  import tktr_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // requests
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  // results
  output logic                  rec_valid,
  input  logic                  rec_stall,
  output rec_t                  rec,
  // configuration
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW   = $clog2(MAX_RECORDS + 1);
  localparam int IW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [IW-1:0]    k, k_next;
  logic             list_dir, list_dir_next;  // direction in effect at the last offer
  logic [CAP_W-1:0] capacity;
  logic             direction;
  logic             rec_next_valid;
  rec_t             rec_next;

  cell_ctl_t        ctl;
  logic [CW-1:0]    live_cnt;
  logic [MAX_RECORDS-1:0] live;
  logic [MAX_RECORDS-1:0] ahead;
  entry_t           cur         [MAX_RECORDS];
  entry_t           left_entry  [MAX_RECORDS];
  entry_t           right_entry [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] left_ahead;
  logic [MAX_RECORDS-1:0] right_ahead;

  entry_t           tail_entry;
  entry_t           last_entry;
  logic [CMPW-1:0]  cap_eff;
  logic             has_room;
  logic             better;
  logic             out_free;
  logic             emit_en;
  logic             is_last;
  logic             last_step;
  logic [31:0]      n_emit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      direction <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_CAPACITY:  capacity  <= cfg_wdata[CAP_W-1:0];
        REG_DIRECTION: direction <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // chain of cells with wrap-around neighbors for rotation
  assign tail_entry = cur[IW'(count - CW'(1))];

  for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
    assign live[g] = (CW'(g) < live_cnt);

    if (g == 0) begin : g_left_head
      assign left_entry[g] = tail_entry;
      assign left_ahead[g] = 1'b0;
    end else begin : g_left
      assign left_entry[g] = cur[g-1];
      assign left_ahead[g] = ahead[g-1];
    end

    if (g == MAX_RECORDS - 1) begin : g_right_end
      assign right_entry[g] = cur[0];
      assign right_ahead[g] = 1'b0;
    end else begin : g_right
      assign right_entry[g] = (CW'(g + 1) == count) ? cur[0] : cur[g+1];
      assign right_ahead[g] = ahead[g+1];
    end

    tktr_cell #(
      .IS_HEAD (g == 0)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .live        (live[g]),
      .left_ahead  (left_ahead[g]),
      .right_ahead (right_ahead[g]),
      .left_entry  (left_entry[g]),
      .right_entry (right_entry[g]),
      .ahead       (ahead[g]),
      .cur         (cur[g])
    );
  end

  // offer decision terms
  assign cap_eff    = (CMPW'(capacity) > CMPW'(MAX_RECORDS)) ?
                      CMPW'(MAX_RECORDS) : CMPW'(capacity);
  assign has_room   = CMPW'(count) < cap_eff;
  assign last_entry = list_dir ? cur[0] : tail_entry;
  assign better     = direction ? ($signed(cmd.value) < $signed(last_entry.value))
                                : ($signed(cmd.value) > $signed(last_entry.value));

  // read-out terms
  assign out_free  = !rec_valid || !rec_stall;
  assign emit_en   = 32'(k) < 32'(OUT_LIMIT);
  assign n_emit    = (32'(count) < 32'(OUT_LIMIT)) ? 32'(count) : 32'(OUT_LIMIT);
  assign is_last   = (32'(k) + 32'd1) == n_emit;
  assign last_step = (CW'(k) + CW'(1)) == count;

  assign cmd_stall = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      k        <= '0;
      list_dir <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      k        <= k_next;
      list_dir <= list_dir_next;
    end
  end

  // next state, chain operation and result
  always_comb begin
    state_next          = state;
    count_next          = count;
    k_next              = k;
    list_dir_next       = list_dir;
    ctl.op              = OP_HOLD;
    ctl.offer_entry.value = cmd.value;
    ctl.offer_entry.id    = cmd.id;
    live_cnt            = count;
    rec_next_valid      = 1'b0;
    rec_next            = '0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.func)
            FUNC_OFFER: begin
              list_dir_next = direction;
              if (has_room) begin
                ctl.op     = OP_INSERT;
                live_cnt   = count;
                count_next = count + CW'(1);
              end else if (count != '0 && better) begin
                if (!list_dir) begin
                  // last entry is the stored tail: drop it by insertion
                  ctl.op   = OP_INSERT;
                  live_cnt = count - CW'(1);
                end else begin
                  // last entry is the stored head
                  ctl.op   = OP_POP_INSERT;
                  live_cnt = count;
                end
              end
            end
            FUNC_CLEAR: count_next = '0;
            FUNC_READ: begin
              state_next = ST_READ;
              k_next     = '0;
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        if (count == '0) begin
          if (out_free) begin
            rec_next_valid     = 1'b1;
            rec_next.empty_res = 1'b1;
            rec_next.last      = 1'b1;
            state_next         = ST_IDLE;
          end
        end else if (!emit_en || out_free) begin
          ctl.op = list_dir ? OP_ROT_RIGHT : OP_ROT_LEFT;
          if (emit_en) begin
            rec_next_valid        = 1'b1;
            rec_next.record_value = list_dir ? tail_entry.value : cur[0].value;
            rec_next.record_id    = list_dir ? tail_entry.id : cur[0].id;
            rec_next.rank         = RANK_W'(k);
            rec_next.last         = is_last;
          end
          k_next = k + IW'(1);
          if (last_step) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (rec_next_valid) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_next_valid) begin
      rec <= rec_next;
    end
  end

endmodule
